@@ design/sfcdc_pkg.sv @@
// ----------------------------------------------------------------------------
// sfcdc_pkg
// shared constants and the tally-to-count function for the squarefree composite divisor count core
// ----------------------------------------------------------------------------
package sfcdc_pkg;

    localparam int VALUE_BITS_DEF = 40;
    localparam int COUNT_BITS     = 12;
    localparam int TALLY_BITS     = 6;
    localparam int COUNT_MAX      = 4095;
    localparam int TALLY_SAT      = 13;

    function automatic logic [COUNT_BITS-1:0] count_from_tally(
        input logic [TALLY_BITS-1:0] tally
    );
        logic [COUNT_BITS:0] full;
        full = '0;
        if (tally >= TALLY_BITS'(TALLY_SAT)) begin
            return COUNT_BITS'(COUNT_MAX);
        end
        full = (COUNT_BITS+1)'(1) << tally;
        full = full - (COUNT_BITS+1)'(tally) - (COUNT_BITS+1)'(1);
        return full[COUNT_BITS-1:0];
    endfunction

endpackage

@@ design/squarefree_composite_divisor_count_core.sv @@
// ----------------------------------------------------------------------------
// squarefree_composite_divisor_count_core
// counts squarefree divisors with two or more distinct prime factors
// ----------------------------------------------------------------------------
// One result per item. The value is factored by trial division (2, then odd
// candidates up to the square root), each trial a bit-serial division, and
// one more such division per found factor power; zero and one skip the
// divider and are answered directly. A two-entry queue lets the input side
// accept while the engine works.
module squarefree_composite_divisor_count_core
    import sfcdc_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [39:0]           s_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COUNT_BITS-1:0] m_qualifying_divisors
);

    logic                f_valid, f_ready, b_valid, b_ready;
    logic [VALUE_BITS:0] f_data, b_data;

    sfcdc_front #(.VALUE_BITS(VALUE_BITS)) u_front (
        .s_valid(s_valid), .s_ready(s_ready), .s_value(s_value),
        .q_valid(f_valid), .q_ready(f_ready), .q_data(f_data)
    );

    sfcdc_fifo #(.WIDTH(VALUE_BITS + 1)) u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
        .out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
    );

    sfcdc_back #(.VALUE_BITS(VALUE_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(b_valid), .q_ready(b_ready), .q_data(b_data),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_qualifying_divisors(m_qualifying_divisors)
    );

endmodule

@@ design/sfcdc_fifo.sv @@
// ----------------------------------------------------------------------------
// sfcdc_fifo
// two-entry queue between the front and back parts
// ----------------------------------------------------------------------------
module sfcdc_fifo #(
    parameter int WIDTH = 40
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wptr_reg, rptr_reg;
    logic [1:0]       cnt_reg;
    logic             push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = mem_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= in_data;
        end
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop)  rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

@@ design/sfcdc_front.sv @@
// ----------------------------------------------------------------------------
// sfcdc_front
// accepts items, masks the value and classifies zero and one as trivial
// ----------------------------------------------------------------------------
module sfcdc_front #(
    parameter int VALUE_BITS = 40
) (
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [39:0]           s_value,
    output logic                  q_valid,
    input  logic                  q_ready,
    output logic [VALUE_BITS:0]   q_data
);

    logic [VALUE_BITS-1:0] val;
    logic                  trivial;

    always_comb begin
        val = '0;
        for (int i = 0; i < VALUE_BITS; i++) begin
            if (i < 40) val[i] = s_value[i];
        end
    end

    assign trivial = (val <= VALUE_BITS'(1));
    assign q_data  = {trivial, val};
    assign q_valid = s_valid;
    assign s_ready = q_ready;

endmodule

@@ design/sfcdc_back.sv @@
// ----------------------------------------------------------------------------
// sfcdc_back
// trial division engine: bit-serial divider, tally and result register
// ----------------------------------------------------------------------------
module sfcdc_back
    import sfcdc_pkg::*;
#(
    parameter int VALUE_BITS = 40
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  logic [VALUE_BITS:0]   q_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COUNT_BITS-1:0] m_qualifying_divisors
);

    localparam int CW = $clog2(VALUE_BITS + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_TEST = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_EVAL = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [VALUE_BITS-1:0] rem_reg, rem_next;
    logic [VALUE_BITS-1:0] trial_reg, trial_next;
    logic [VALUE_BITS-1:0] quo_reg, quo_next;
    logic [VALUE_BITS-1:0] part_reg, part_next;
    logic [CW-1:0]         bit_reg, bit_next;
    logic [TALLY_BITS-1:0] tally_reg, tally_next;
    logic                  hit_reg, hit_next;
    logic                  out_valid_reg, out_valid_next;
    logic [COUNT_BITS-1:0] out_reg, out_next;

    logic [VALUE_BITS:0]   shifted;
    logic [VALUE_BITS:0]   diff;

    assign q_ready               = (state_reg == ST_IDLE) && !out_valid_reg;
    assign m_valid               = out_valid_reg;
    assign m_qualifying_divisors = out_reg;

    assign shifted = {part_reg, rem_reg[bit_reg]};
    assign diff    = shifted - {1'b0, trial_reg};

    always_comb begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        trial_next     = trial_reg;
        quo_next       = quo_reg;
        part_next      = part_reg;
        bit_next       = bit_reg;
        tally_next     = tally_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_valid_reg && m_ready) out_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid && q_ready) begin
                    rem_next   = q_data[VALUE_BITS-1:0];
                    trial_next = VALUE_BITS'(2);
                    tally_next = '0;
                    hit_next   = 1'b0;
                    if (q_data[VALUE_BITS]) begin
                        out_next       = '0;
                        out_valid_next = 1'b1;
                    end else begin
                        state_next = ST_TEST;
                    end
                end
            end
            ST_TEST: begin
                // start rem / trial
                part_next  = '0;
                quo_next   = '0;
                bit_next   = CW'(VALUE_BITS - 1);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (!diff[VALUE_BITS]) begin
                    part_next = diff[VALUE_BITS-1:0];
                    quo_next  = {quo_reg[VALUE_BITS-2:0], 1'b1};
                end else begin
                    part_next = shifted[VALUE_BITS-1:0];
                    quo_next  = {quo_reg[VALUE_BITS-2:0], 1'b0};
                end
                if (bit_reg == '0) state_next = ST_EVAL;
                else bit_next = bit_reg - CW'(1);
            end
            ST_EVAL: begin
                if (part_reg == '0) begin
                    // divides: strip and tally once
                    if (!hit_reg) tally_next = tally_reg + TALLY_BITS'(1);
                    hit_next   = 1'b1;
                    rem_next   = quo_reg;
                    state_next = ST_TEST;
                end else begin
                    hit_next = 1'b0;
                    if (trial_reg == VALUE_BITS'(2)) trial_next = VALUE_BITS'(3);
                    else trial_next = trial_reg + VALUE_BITS'(2);
                    // loop continues while rem > 1 and (after trial 2 or quo (rem / old trial) >= next trial)
                    if (rem_reg > VALUE_BITS'(1) &&
                        (trial_reg == VALUE_BITS'(2) || quo_reg >= trial_next)) begin
                        state_next = ST_TEST;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (!out_valid_reg) begin
                    if (rem_reg > VALUE_BITS'(1)) begin
                        out_next = count_from_tally(tally_reg + TALLY_BITS'(1));
                    end else begin
                        out_next = count_from_tally(tally_reg);
                    end
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        rem_reg   <= rem_next;
        trial_reg <= trial_next;
        quo_reg   <= quo_next;
        part_reg  <= part_next;
        bit_reg   <= bit_next;
        tally_reg <= tally_next;
        hit_reg   <= hit_next;
        out_reg   <= out_next;
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ bench/squarefree_composite_divisor_count_core_tb.sv @@
// ----------------------------------------------------------------------------
// squarefree_composite_divisor_count_core_tb
// drives values through the core and checks each divisor count against the table or a
// trial-division predictor; directed table first, then random and smooth values
// ----------------------------------------------------------------------------
module squarefree_composite_divisor_count_core_tb;
    import sfcdc_pkg::*;

    localparam int VBITS = VALUE_BITS_DEF;

    typedef struct {
        logic [39:0]           value;
        bit                    typed;
        logic [COUNT_BITS-1:0] count;
    } vector_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [39:0]           s_value;
    logic                  m_valid;
    logic                  m_ready;
    logic [COUNT_BITS-1:0] m_qualifying_divisors;

    logic [COUNT_BITS-1:0] pending_counts[$];
    int                    mismatches;
    int                    results_seen;
    int                    stall_left;
    bit                    steady_sink;
    bit                    steady_source;
    vector_t               vectors[$];

    squarefree_composite_divisor_count_core uut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_value               (s_value),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_qualifying_divisors (m_qualifying_divisors)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    function automatic logic [COUNT_BITS-1:0] divisor_count(logic [39:0] raw);
        logic [63:0] rest;
        logic [63:0] probe;
        int          primes;
        rest = 64'(raw) & ((64'd1 << VBITS) - 64'd1);
        primes = 0;
        if (rest == 0) begin
            return '0;
        end
        if (rest % 2 == 0) begin
            primes++;
            while (rest % 2 == 0) rest = rest / 2;
        end
        probe = 3;
        while (rest > 1 && probe <= rest / probe) begin
            if (rest % probe == 0) begin
                primes++;
                while (rest % probe == 0) rest = rest / probe;
            end
            probe += 2;
        end
        if (rest > 1) begin
            primes++;
        end
        if (primes >= 13) begin
            return COUNT_BITS'(COUNT_MAX);
        end
        return COUNT_BITS'((64'd1 << primes) - 64'(primes) - 64'd1);
    endfunction

    // product of a small power of two and random factors from 3 to 400, kept inside 40 bits
    function automatic logic [39:0] smooth_value();
        logic [63:0] acc;
        logic [63:0] p;
        int          terms;
        acc = 64'd1 << $urandom_range(0, 3);
        terms = $urandom_range(1, 14);
        for (int i = 0; i < terms; i++) begin
            p = 64'($urandom_range(3, 400));
            if (acc * p < (64'd1 << 40)) acc = acc * p;
        end
        return acc[39:0];
    endfunction

    task automatic report(string what, logic [COUNT_BITS-1:0] got,
                          logic [COUNT_BITS-1:0] want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    task automatic send_value(logic [39:0] v, logic [COUNT_BITS-1:0] want);
        int gap;
        gap = steady_source ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_counts.push_back(want);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else if (m_valid && m_ready) begin
            results_seen++;
            if (pending_counts.size() == 0) begin
                report("unexpected item", m_qualifying_divisors, '0);
            end else begin
                logic [COUNT_BITS-1:0] want;
                want = pending_counts.pop_front();
                if (m_qualifying_divisors !== want) begin
                    report("qualifying_divisors", m_qualifying_divisors, want);
                end
            end
            stall_left = steady_sink ? 0 : $urandom_range(0, 11);
            m_ready <= (stall_left == 0);
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= (stall_left == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        #400_000_000;
        $display("squarefree_composite_divisor_count_core verification failed");
        $finish;
    end

    initial begin
        logic [39:0] v;
        mismatches = 0;
        results_seen = 0;
        steady_sink = 1'b0;
        steady_source = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_value = '0;
        vectors = '{
            '{40'd0, 1, 12'd0},
            '{40'd1, 1, 12'd0},
            '{40'd2, 1, 12'd0},
            '{40'd3, 1, 12'd0},
            '{40'd4, 1, 12'd0},
            '{40'd6, 1, 12'd1},
            '{40'd30, 1, 12'd4},
            '{40'd210, 1, 12'd11},
            '{40'h80_0000_0000, 1, 12'd0},
            '{40'hFF_FFFF_FFFF, 1, 12'd120},
            '{40'd200560490130, 1, 12'd2036},
            '{40'd1000003, 1, 12'd0},
            '{40'd1018081, 1, 12'd0},
            '{40'd1000006, 0, 12'd0},
            '{40'd3486784401, 0, 12'd0},
            '{40'd36, 0, 12'd0},
            '{40'd65535, 0, 12'd0},
            '{40'hAA_AAAA_AAAA, 0, 12'd0},
            '{40'h55_5555_5555, 0, 12'd0},
            '{40'd9699690, 0, 12'd0}
        };
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (vectors[i]) begin
            send_value(vectors[i].value,
                       vectors[i].typed ? vectors[i].count
                                        : divisor_count(vectors[i].value));
        end
        for (int n = 0; n < 80; n++) begin
            if (n % 25 == 0) begin
                steady_source = ($urandom_range(0, 2) == 0);
                steady_sink = ($urandom_range(0, 2) == 0);
            end
            case ($urandom_range(0, 9))
                0: v = 40'($urandom_range(0, 65535));
                1: v = 40'($urandom_range(0, 1 << 22));
                2: v = {8'($urandom), 32'($urandom)} >> $urandom_range(30, 39);
                default: v = smooth_value();
            endcase
            send_value(v, divisor_count(v));
        end
        s_valid <= 1'b0;
        while (pending_counts.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (mismatches == 0 && pending_counts.size() == 0) begin
            $display("squarefree_composite_divisor_count_core verification clean");
        end else begin
            $display("squarefree_composite_divisor_count_core verification failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/sfcdc_pkg.sv
design/sfcdc_fifo.sv
design/sfcdc_front.sv
design/sfcdc_back.sv
design/squarefree_composite_divisor_count_core.sv
bench/squarefree_composite_divisor_count_core_tb.sv
